@@ sv/tkss_pkg.sv @@
// Shared types and constants for the top-k score selector.
// Used by tkss_cell, top_k_score_select and tkss_checker; depends on nothing.
`default_nettype none

package tkss_pkg;

    // Default sizes handed to the top level.
    localparam int DEF_MAX_ITEMS = 256;
    localparam int DEF_MAX_K     = 8;

    // Fixed field widths of the stream payloads.
    localparam int SCORE_W    = 32;
    localparam int TOP_CNT_W  = 4;
    localparam int RANK_W     = 3;
    localparam int OUT_IDX_W  = 8;
    localparam int OUT_DATA_W = 16;

    // Value of the result count register after reset.
    localparam logic [TOP_CNT_W-1:0] TOP_COUNT_RST = 4'd6;

    // Commands broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic insert;     // place the new score into the sorted list
        logic shift_out;  // move every entry one place toward the head
        logic clear;      // drop all entries at the end of a set
    } cell_ctl_t;

endpackage

`default_nettype wire

@@ sv/tkss_cell.sv @@
// One cell of the sorted insertion chain: holds a single (score, index) entry.
// Depends on tkss_pkg for the command struct and the score width.
`default_nettype none

module tkss_cell #(
    parameter int IDX_W = 8
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  tkss_pkg::cell_ctl_t           ctl,
    input  wire  [tkss_pkg::SCORE_W-1:0]  new_score,
    input  wire  [IDX_W-1:0]              new_idx,
    input  wire                           left_beat,
    input  wire                           left_valid,
    input  wire  [tkss_pkg::SCORE_W-1:0]  left_score,
    input  wire  [IDX_W-1:0]              left_idx,
    input  wire                           right_valid,
    input  wire  [tkss_pkg::SCORE_W-1:0]  right_score,
    input  wire  [IDX_W-1:0]              right_idx,
    output logic                          beat,
    output logic                          valid,
    output logic [tkss_pkg::SCORE_W-1:0]  score,
    output logic [IDX_W-1:0]              idx
);
    import tkss_pkg::*;

    logic                valid_reg, valid_next;
    logic [SCORE_W-1:0]  score_reg, score_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;

    // The new score displaces this entry only if it is strictly greater,
    // so an equal earlier score keeps its place ahead of the later one.
    assign beat = !valid_reg || ($signed(new_score) > $signed(score_reg));

    // Next entry: insertion pulls from the left neighbor or takes the new
    // score; drain pulls from the right neighbor.
    always_comb
    begin
        valid_next = valid_reg;
        score_next = score_reg;
        idx_next   = idx_reg;
        priority if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.shift_out)
        begin
            valid_next = right_valid;
            score_next = right_score;
            idx_next   = right_idx;
        end
        else if (ctl.insert && beat)
        begin
            if (left_beat)
            begin
                valid_next = left_valid;
                score_next = left_score;
                idx_next   = left_idx;
            end
            else
            begin
                valid_next = 1'b1;
                score_next = new_score;
                idx_next   = new_idx;
            end
        end
    end

    // Only the valid bit needs a reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        idx_reg   <= idx_next;
    end

    assign valid = valid_reg;
    assign score = score_reg;
    assign idx   = idx_reg;

endmodule

`default_nettype wire

@@ sv/top_k_score_select.sv @@
// Top-k score selector: a chain of tkss_cell entries kept in descending order
// plus a sequencer that counts the set and drains the ranks.
// Depends on tkss_pkg and tkss_cell.
//
//   Channel   Dir   Handshake          Payload
//   s_*       in    s_tvalid/s_tready  s_tdata = score, s_tlast = last of set
//   m_*       out   m_tvalid/m_tready  m_tdata = rank, item_index;
//                                      m_tuser = found; m_tlast = final_res
//   cfg_*     in    cfg_valid/ready    cfg_data = top_count
//
// Scores are taken one per cycle and, up to MAX_ITEMS per set, sorted into the chain
// of MAX_K cells at the accepting edge. After the last score, the clamped count (1 to
// MAX_K) of results follows from the next cycle, one per cycle while m_tready is high.
// Input is held off for that drain and reopens the cycle after the final result.
// A stalled result holds; the chain shifts only when a result is taken.
// Reset empties the chain, zeroes the item count and sets top_count to 6.
`default_nettype none

module top_k_score_select #(
    parameter int MAX_ITEMS = tkss_pkg::DEF_MAX_ITEMS,
    parameter int MAX_K     = tkss_pkg::DEF_MAX_K
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // Score stream: tdata [31:0] score.
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [tkss_pkg::SCORE_W-1:0]     s_tdata,
    input  wire                              s_tlast,
    // Result stream: tdata [2:0] rank, [10:3] item_index, [15:11] zero.
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [tkss_pkg::OUT_DATA_W-1:0]  m_tdata,
    // tuser [0] found.
    output logic [0:0]                       m_tuser,
    output logic                             m_tlast,
    // Result count register write.
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [tkss_pkg::TOP_CNT_W-1:0]   cfg_data
);
    import tkss_pkg::*;

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int RK_W  = $clog2(MAX_K + 1);

    typedef enum logic {ST_LOAD, ST_EMIT} state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [RK_W-1:0]       rank_reg;
    logic [RK_W-1:0]       k_reg;
    logic [TOP_CNT_W-1:0]  top_count_reg;

    logic                  s_fire, m_fire, room, is_final;
    logic [RK_W-1:0]       k_clamped;
    logic [31:0]           tc_ext, rank_ext, idx_ext;
    cell_ctl_t             ctl;

    logic                  beat_w  [MAX_K];
    logic                  valid_w [MAX_K];
    logic [SCORE_W-1:0]    score_w [MAX_K];
    logic [IDX_W-1:0]      idx_w   [MAX_K];

    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_tvalid && m_tready;
    assign room      = (count_reg < CNT_W'(MAX_ITEMS));
    assign is_final  = (rank_reg == (k_reg - 1'b1));
    assign cfg_ready = 1'b1;

    // Result count clamped to 1..MAX_K.
    assign tc_ext = 32'(top_count_reg);
    always_comb
    begin
        priority if (tc_ext == 32'd0)
            k_clamped = RK_W'(1);
        else if (tc_ext > 32'(MAX_K))
            k_clamped = RK_W'(MAX_K);
        else
            k_clamped = RK_W'(tc_ext);
    end

    // Commands to the chain.
    always_comb
    begin
        ctl.insert    = s_fire && room;
        ctl.shift_out = m_fire && !is_final;
        ctl.clear     = m_fire && is_final;
    end

    // The chain of cells, head at index 0.
    for (genvar i = 0; i < MAX_K; i++)
    begin : g_cell
        logic               l_beat, l_valid, r_valid;
        logic [SCORE_W-1:0] l_score, r_score;
        logic [IDX_W-1:0]   l_idx, r_idx;

        if (i == 0)
        begin : g_head
            assign l_beat  = 1'b0;
            assign l_valid = 1'b0;
            assign l_score = '0;
            assign l_idx   = '0;
        end
        else
        begin : g_mid
            assign l_beat  = beat_w[i-1];
            assign l_valid = valid_w[i-1];
            assign l_score = score_w[i-1];
            assign l_idx   = idx_w[i-1];
        end

        if (i == MAX_K - 1)
        begin : g_tail
            assign r_valid = 1'b0;
            assign r_score = '0;
            assign r_idx   = '0;
        end
        else
        begin : g_body
            assign r_valid = valid_w[i+1];
            assign r_score = score_w[i+1];
            assign r_idx   = idx_w[i+1];
        end

        tkss_cell #(
            .IDX_W(IDX_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .new_score  (s_tdata),
            .new_idx    (count_reg[IDX_W-1:0]),
            .left_beat  (l_beat),
            .left_valid (l_valid),
            .left_score (l_score),
            .left_idx   (l_idx),
            .right_valid(r_valid),
            .right_score(r_score),
            .right_idx  (r_idx),
            .beat       (beat_w[i]),
            .valid      (valid_w[i]),
            .score      (score_w[i]),
            .idx        (idx_w[i])
        );
    end

    // Sequencer: count the set, then drain one rank per taken request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            rank_reg      <= '0;
            k_reg         <= RK_W'(1);
            top_count_reg <= TOP_COUNT_RST;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                top_count_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (s_fire)
                    begin
                        if (room)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        if (s_tlast)
                        begin
                            k_reg     <= k_clamped;
                            rank_reg  <= '0;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (m_fire)
                    begin
                        if (is_final)
                        begin
                            count_reg <= '0;
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            rank_reg <= rank_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // Index and found fields come from the head cell; the rank comes from the rank counter.
    assign rank_ext = 32'(rank_reg);
    assign idx_ext  = valid_w[0] ? 32'(idx_w[0]) : 32'd0;

    assign s_tready   = (state_reg == ST_LOAD);
    assign m_tvalid   = (state_reg == ST_EMIT);
    assign m_tdata    = {{(OUT_DATA_W - OUT_IDX_W - RANK_W){1'b0}},
                         idx_ext[OUT_IDX_W-1:0], rank_ext[RANK_W-1:0]};
    assign m_tuser[0] = valid_w[0];
    assign m_tlast    = is_final;

endmodule

`default_nettype wire

@@ sv/tkss_checker.sv @@
// Port-level checks for top_k_score_select, attached by the bind below.
// Depends on tkss_pkg for the payload widths.
`default_nettype none

module tkss_port_checks (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              s_tvalid,
    input wire                              s_tready,
    input wire                              s_tlast,
    input wire                              m_tvalid,
    input wire                              m_tready,
    input wire [tkss_pkg::OUT_DATA_W-1:0]   m_tdata,
    input wire [0:0]                        m_tuser,
    input wire                              m_tlast
);
    import tkss_pkg::*;

    // Input is never taken while results are being delivered.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("score request accepted during result drain");

    // The last score of a set starts the results on the next cycle.
    a_emit_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("no result after the last score");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
                                     && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed");

    // A rank without a score reports index zero.
    a_empty_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[RANK_W+OUT_IDX_W-1:RANK_W] == '0))
        else $error("empty rank with nonzero index");

    // Once a rank is empty, every later rank of the set is empty too.
    a_empty_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tuser[0] && !m_tlast) |=>
            (m_tvalid && !m_tuser[0]))
        else $error("score found after an empty rank");

endmodule

bind top_k_score_select tkss_port_checks u_tkss_port_checks (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);

`default_nettype wire
